### src/sode_pkg.sv
// shared constants and codes for the set overlap distance engine
package sode_pkg;

    // input and result field widths
    localparam int MODE_W      = 2;
    localparam int CUST_W      = 5;
    localparam int PROD_W      = 6;
    localparam int INTER_OUT_W = 7;
    localparam int DIST_W      = 17;
    localparam int FRAC_W      = 16;

    // configuration register widths and reset values
    localparam int NC_W   = 6;
    localparam int NP_W   = 7;
    localparam int CFG_W  = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [NC_W-1:0] NC_RESET = 6'd32;
    localparam logic [NP_W-1:0] NP_RESET = 7'd64;
    localparam int CUST_LIMIT = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CUSTOMERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PRODUCTS  = 1'b1;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // purchase count and distance format
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 8'hFF;
    localparam logic [DIST_W-1:0] Q16_ONE   = 17'h10000;

    // defaults for the top level parameters
    localparam int DEF_MAX_CUSTOMERS = 32;
    localparam int DEF_MAX_PRODUCTS  = 64;

endpackage

### src/sode_store.sv
// customer store: purchase rows and counts in one memory with per-entry valid bits
module sode_store
    import sode_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_CUSTOMERS,
    parameter int ROW_W = DEF_MAX_PRODUCTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [ROW_W-1:0] wr_row,
    input  logic [CNT_W-1:0] wr_cnt,
    output logic [ROW_W-1:0] rd_row,
    output logic [CNT_W-1:0] rd_cnt
);

    localparam int ENTRY_W = ROW_W + CNT_W;

    logic [ENTRY_W-1:0] entry_mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               rvalid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= {wr_cnt, wr_row};
        end
        if (rd_en) begin
            rdata_reg <= entry_mem[rd_addr];
        end
    end

    // an entry never written since reset or the last clear reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rvalid_reg ? rdata_reg[ROW_W-1:0] : '0;
    assign rd_cnt = rvalid_reg ? rdata_reg[ENTRY_W-1:ROW_W] : '0;

endmodule

### src/sode_overlap.sv
// registered popcount of the overlap of two purchase rows
module sode_overlap
    import sode_pkg::*;
#(
    parameter int ROW_W   = DEF_MAX_PRODUCTS,
    parameter int INTER_W = $clog2(ROW_W + 1)
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [ROW_W-1:0]   row_a,
    input  logic [ROW_W-1:0]   row_b,
    output logic [INTER_W-1:0] inter
);

    localparam int NGRP  = (ROW_W + 7) / 8;
    localparam int PAD_W = NGRP * 8;

    logic [PAD_W-1:0]   both;
    logic [3:0]         grp_sum [NGRP];
    logic [INTER_W-1:0] total;
    logic [INTER_W-1:0] inter_reg;

    // byte-wide partial counts, then a sum over the bytes
    always_comb begin
        both = PAD_W'(row_a & row_b);
        for (int g = 0; g < NGRP; g++) begin
            grp_sum[g] = 4'd0;
            for (int b = 0; b < 8; b++) begin
                grp_sum[g] = grp_sum[g] + 4'(both[g*8+b]);
            end
        end
        total = '0;
        for (int g = 0; g < NGRP; g++) begin
            total = total + INTER_W'(grp_sum[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inter_reg <= total;
        end
    end

    assign inter = inter_reg;

endmodule

### src/sode_divider.sv
// restoring divider, two quotient bits per cycle
module sode_divider
    import sode_pkg::*;
#(
    parameter int NUM_W = 23,
    parameter int QUO_W = 2 * ((NUM_W + 1) / 2)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [CNT_W-1:0] denom,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int STEPS  = QUO_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [QUO_W-1:0]  num_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;

    logic [CNT_W:0]    den_x;
    logic [CNT_W:0]    r1, r1s, r2, r2s;
    logic              qa, qb;
    logic [QUO_W-1:0]  num_next;
    logic [CNT_W-1:0]  rem_next;

    always_comb begin
        den_x    = {1'b0, den_reg};
        r1       = {rem_reg, num_reg[QUO_W-1]};
        qa       = (r1 >= den_x);
        r1s      = qa ? (r1 - den_x) : r1;
        r2       = {r1s[CNT_W-1:0], num_reg[QUO_W-2]};
        qb       = (r2 >= den_x);
        r2s      = qb ? (r2 - den_x) : r2;
        rem_next = r2s[CNT_W-1:0];
        // numerator bits leave at the top, quotient bits enter at the bottom
        num_next = {num_reg[QUO_W-3:0], qa, qb};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(STEPS);
                num_reg  <= QUO_W'(numer);
                rem_reg  <= '0;
                den_reg  <= denom;
            end else if (busy_reg) begin
                num_reg  <= num_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

### src/set_overlap_distance_engine.sv
// set overlap distance engine: purchase store, query sequencer and result register
//
// Input items arrive on the s_ channel: tuser carries the kind (record, query,
// clear), tdata the customer and product. A record sets the product's bit in
// the customer's row and bumps its saturating count, as a read and a write
// back of the store memory. A clear empties the store in the cycle it is
// taken. A query for customer i emits one result per active customer j on the
// m_ channel, the final one with tlast set. Each result's Q1.16 distance is
// formed by the two-bit-per-cycle divider. Registers are to be written by
// the user through the cfg_ port only while the block is idle; the block
// itself does not enforce this. Results wait in an output register; when the
// receiver stalls the query holds until that register is free, and a new
// input item is taken while the last result still waits. Reset empties the
// store (valid bits cleared at once, no sweep), restores the registers to
// their defaults and drops m_tvalid.
module set_overlap_distance_engine
    import sode_pkg::*;
#(
    parameter int MAX_CUSTOMERS = DEF_MAX_CUSTOMERS,
    parameter int MAX_PRODUCTS  = DEF_MAX_PRODUCTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // customer, product
    input  logic [MODE_W-1:0]    s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // other_customer, intersection, distance
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW       = $clog2(MAX_CUSTOMERS);
    localparam int INTER_W  = $clog2(MAX_PRODUCTS + 1);
    localparam int NUM_W    = INTER_W + FRAC_W;
    localparam int QUO_W    = 2 * ((NUM_W + 1) / 2);
    localparam int CUST_CAP = (MAX_CUSTOMERS < CUST_LIMIT) ? MAX_CUSTOMERS : CUST_LIMIT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC_MOD,
        ST_Q_ROW,
        ST_Q_POP,
        ST_Q_DIVST,
        ST_Q_DIV,
        ST_Q_OUT
    } state_t;

    state_t state_reg;

    logic [NC_W-1:0] num_customers_reg;
    logic [NP_W-1:0] num_products_reg;
    logic [NC_W-1:0] nc_act;
    logic [NP_W-1:0] np_act;
    logic [MAX_PRODUCTS-1:0] prod_mask;

    logic [MODE_W-1:0] mode_in;
    logic [CUST_W-1:0] cust_in;
    logic [PROD_W-1:0] prod_in;
    logic              s_accept;
    logic              rec_ok;
    logic              qry_ok;

    logic [AW-1:0]     rec_addr_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [MAX_PRODUCTS-1:0] row_i_reg;
    logic [CNT_W-1:0]  cnt_i_reg;
    logic [CUST_W-1:0] j_reg;
    logic              j_last;

    logic                    st_clear;
    logic                    st_rd_en;
    logic [AW-1:0]           st_rd_addr;
    logic                    st_wr_en;
    logic [MAX_PRODUCTS-1:0] st_wr_row;
    logic [CNT_W-1:0]        st_wr_cnt;
    logic [MAX_PRODUCTS-1:0] st_rd_row;
    logic [CNT_W-1:0]        st_rd_cnt;
    logic [MAX_PRODUCTS-1:0] prod_onehot;

    logic [INTER_W-1:0] inter;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [DIST_W-1:0]  dist_val;

    logic                   m_tvalid_reg;
    logic [CUST_W-1:0]      out_cust_reg;
    logic [INTER_OUT_W-1:0] out_inter_reg;
    logic [DIST_W-1:0]      out_dist_reg;
    logic                   out_last_reg;
    logic                   out_free;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_customers_reg <= NC_RESET;
            num_products_reg  <= NP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUM_CUSTOMERS: num_customers_reg <= cfg_wdata[NC_W-1:0];
                CFG_NUM_PRODUCTS:  num_products_reg  <= cfg_wdata[NP_W-1:0];
                default: ;
            endcase
        end
    end

    assign nc_act = (num_customers_reg > NC_W'(CUST_CAP)) ? NC_W'(CUST_CAP)
                                                          : num_customers_reg;
    assign np_act = (num_products_reg > NP_W'(MAX_PRODUCTS)) ? NP_W'(MAX_PRODUCTS)
                                                             : num_products_reg;

    always_comb begin
        for (int k = 0; k < MAX_PRODUCTS; k++) begin
            prod_mask[k]   = (NP_W'(k) < np_act);
            prod_onehot[k] = ({1'b0, prod_reg} == NP_W'(k));
        end
    end

    // input decode
    assign mode_in  = s_tuser;
    assign cust_in  = s_tdata[CUST_W-1:0];
    assign prod_in  = s_tdata[CUST_W+PROD_W-1:CUST_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign rec_ok   = (mode_in == MODE_RECORD)
                   && (9'(cust_in) < 9'(MAX_CUSTOMERS))
                   && ({1'b0, prod_in} < np_act);
    assign qry_ok   = (mode_in == MODE_QUERY) && ({1'b0, cust_in} < nc_act);

    assign j_last   = ({1'b0, j_reg} == nc_act - NC_W'(1));
    assign out_free = !m_tvalid_reg || m_tready;

    // store requests
    always_comb begin
        st_rd_en   = 1'b0;
        st_rd_addr = AW'(cust_in);
        case (state_reg)
            ST_IDLE: begin
                st_rd_en = s_accept && (rec_ok || qry_ok);
            end
            ST_Q_ROW: begin
                st_rd_en   = 1'b1;
                st_rd_addr = AW'(j_reg);
            end
            ST_Q_OUT: begin
                st_rd_en   = out_free && !j_last;
                st_rd_addr = AW'(j_reg + CUST_W'(1));
            end
            default: ;
        endcase
    end

    assign st_clear  = s_accept && (mode_in == MODE_CLEAR);
    assign st_wr_en  = (state_reg == ST_REC_MOD);
    assign st_wr_row = st_rd_row | prod_onehot;
    assign st_wr_cnt = (st_rd_cnt == COUNT_MAX) ? st_rd_cnt : st_rd_cnt + CNT_W'(1);

    sode_store #(
        .DEPTH (MAX_CUSTOMERS),
        .ROW_W (MAX_PRODUCTS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (st_clear),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .wr_en   (st_wr_en),
        .wr_addr (rec_addr_reg),
        .wr_row  (st_wr_row),
        .wr_cnt  (st_wr_cnt),
        .rd_row  (st_rd_row),
        .rd_cnt  (st_rd_cnt)
    );

    sode_overlap #(
        .ROW_W   (MAX_PRODUCTS),
        .INTER_W (INTER_W)
    ) u_overlap (
        .aclk  (aclk),
        .en    (state_reg == ST_Q_POP),
        .row_a (row_i_reg),
        .row_b (st_rd_row),
        .inter (inter)
    );

    assign div_start = (state_reg == ST_Q_DIVST);

    sode_divider #(
        .NUM_W (NUM_W),
        .QUO_W (QUO_W)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   ({inter, FRAC_W'(0)}),
        .denom   (cnt_i_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // empty count means full distance, an overlap beyond the count clips at zero
    always_comb begin
        if (cnt_i_reg == '0) begin
            dist_val = Q16_ONE;
        end else if (div_quo > QUO_W'(Q16_ONE)) begin
            dist_val = '0;
        end else begin
            dist_val = DIST_W'(QUO_W'(Q16_ONE) - div_quo);
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            j_reg        <= '0;
        end else begin
            if (state_reg == ST_Q_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && rec_ok) begin
                        rec_addr_reg <= AW'(cust_in);
                        prod_reg     <= prod_in;
                        state_reg    <= ST_REC_MOD;
                    end else if (s_accept && qry_ok) begin
                        j_reg     <= '0;
                        state_reg <= ST_Q_ROW;
                    end
                end
                ST_REC_MOD: begin
                    state_reg <= ST_IDLE;
                end
                ST_Q_ROW: begin
                    row_i_reg <= st_rd_row & prod_mask;
                    cnt_i_reg <= st_rd_cnt;
                    state_reg <= ST_Q_POP;
                end
                ST_Q_POP: begin
                    state_reg <= ST_Q_DIVST;
                end
                ST_Q_DIVST: begin
                    state_reg <= ST_Q_DIV;
                end
                ST_Q_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_Q_OUT;
                    end
                end
                ST_Q_OUT: begin
                    if (out_free) begin
                        out_cust_reg  <= j_reg;
                        out_inter_reg <= INTER_OUT_W'(inter);
                        out_dist_reg  <= dist_val;
                        out_last_reg  <= j_last;
                        if (j_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            j_reg     <= j_reg + CUST_W'(1);
                            state_reg <= ST_Q_POP;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_dist_reg, out_inter_reg, out_cust_reg};

`ifndef NO_ASSERTIONS
    // the flagged result belongs to the last active customer
    a_last_is_final_customer: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> ({1'b0, m_tdata[4:0]} == nc_act - NC_W'(1)))
        else $error("tlast on a result that is not the final customer");

    a_dist_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[28:12] <= Q16_ONE))
        else $error("distance above one");

    a_div_done_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_Q_DIV))
        else $error("divider finished outside its wait state");

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        st_wr_en |-> !st_rd_en)
        else $error("store read and write in the same cycle");

    a_query_keeps_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_REC_MOD) |-> (!st_wr_en && !st_clear))
        else $error("store changed during a query");
`endif

endmodule
